[sv/hbd_pkg.sv]
// Shared types, constants and register codes for the H-bridge drive block.
`default_nettype none
package hbd_pkg;

	localparam int unsigned CMD_W    = 16;
	localparam int unsigned CNT_W    = 32;
	localparam int unsigned EL_W     = 32;
	localparam int unsigned WRAP_W   = 16;
	localparam int unsigned ALPHA_W  = 17;
	localparam int unsigned SPD_W    = 32;
	localparam int unsigned DIVD_W   = 56;
	localparam int unsigned DSOR_W   = 32;
	localparam int unsigned STEP_W   = 6;
	localparam int unsigned MA_W     = 33;
	localparam int unsigned MB_W     = 28;
	localparam int unsigned MP_W     = MA_W + MB_W;
	localparam int unsigned CFGA_W   = 1;
	localparam int unsigned IN_W     = 80;
	localparam int unsigned OUT_W    = 56;
	// x / 10000 == ((x >> 4) * LVL_RCP) >> LVL_SHIFT for x below 2^31
	localparam int unsigned LVL_SHIFT = 36;

	localparam logic [DSOR_W-1:0] CMD_FULL    = 32'd10000;
	localparam logic [MB_W-1:0]   SPEED_SCALE = 28'd7515772;
	localparam logic [MB_W-1:0]   LVL_RCP     = 28'd109951163;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'd65536;
	localparam logic [WRAP_W-1:0] WRAP_RST    = 16'd999;
	localparam logic [ALPHA_W-1:0] ALPHA_RST  = 17'd32768;
	localparam logic [STEP_W-1:0] SPD_STEPS   = 6'd56;

	localparam logic [CFGA_W-1:0] REG_PWM_WRAP     = 1'b0;
	localparam logic [CFGA_W-1:0] REG_FILTER_ALPHA = 1'b1;

	typedef struct packed {
		logic signed [CMD_W-1:0] speed_cmd;
		logic signed [CNT_W-1:0] encoder_count;
		logic [EL_W-1:0]         elapsed_us;
	} hbd_item_t;

	typedef struct packed {
		logic [WRAP_W-1:0]  pwm_wrap;
		logic [ALPHA_W-1:0] filter_alpha;
	} hbd_cfg_t;

	typedef struct packed {
		logic                    in1_pwm;
		logic                    in2_pwm;
		logic [WRAP_W-1:0]       pwm_level;
		logic                    is_braked;
		logic                    pins_changed;
		logic signed [SPD_W-1:0] filtered_speed;
	} hbd_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LMUL,
		ST_LRCP,
		ST_LVL,
		ST_SMUL,
		ST_SGO,
		ST_SWAIT,
		ST_EMA1,
		ST_EMA2,
		ST_EMA3,
		ST_DONE
	} hbd_state_t;

endpackage
`default_nettype wire

[sv/hbd_div.sv]
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none
module hbd_div import hbd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIVD_W-1:0] dividend,
	input  wire logic [DSOR_W-1:0] divisor,
	input  wire logic [STEP_W-1:0] steps,
	output logic                   done,
	output logic [DIVD_W-1:0]      quotient
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIVD_W-1:0] d_q;
	logic [DSOR_W-1:0] r_q;
	logic [DIVD_W-1:0] q_q;
	logic [DSOR_W-1:0] dv_q;
	logic [DSOR_W:0]   trial;
	logic [DSOR_W:0]   diff;
	logic              fits;

	assign trial = {r_q, d_q[DIVD_W-1]};
	assign diff  = trial - {1'b0, dv_q};
	assign fits  = (trial >= {1'b0, dv_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q  <= dividend;
			r_q  <= '0;
			q_q  <= '0;
			dv_q <= divisor;
		end else if (busy_q) begin
			d_q <= {d_q[DIVD_W-2:0], 1'b0};
			r_q <= fits ? diff[DSOR_W-1:0] : trial[DSOR_W-1:0];
			q_q <= {q_q[DIVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = q_q;

endmodule
`default_nettype wire

[sv/hbd_core.sv]
// Sequencer and datapath: shared multiplier, divider control, drive state and speed filter.
`default_nettype none
module hbd_core import hbd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire hbd_item_t item,
	input  wire hbd_cfg_t  cfg,
	input  wire logic      res_ready,
	output logic           idle,
	output logic           res_valid,
	output hbd_res_t       res
);

	hbd_state_t state_q, state_d;

	// drive and filter state
	logic              last_dir_q;
	logic              brake_q;
	logic [CNT_W-1:0]  last_cnt_q;
	logic [SPD_W-1:0]  last_spd_q;

	// per-request working registers
	logic [CMD_W-1:0]  cmd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [EL_W-1:0]   el_q;
	logic              brk_q;
	logic              dir_q;
	logic              chg_q;
	logic              hold_q;
	logic              neg_q;
	logic [CNT_W-1:0]  dmag_q;
	logic [MP_W-1:0]   prod_q;
	logic [MP_W-1:0]   sum_q;
	logic [WRAP_W-1:0] level_q;
	logic [SPD_W-1:0]  raw_q;
	logic [SPD_W-1:0]  speed_q;

	logic [CMD_W-1:0]   cmd_mag;
	logic [CNT_W-1:0]   delta;
	logic [ALPHA_W-1:0] alpha_c;
	logic [ALPHA_W-1:0] alpha_inv;
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [MP_W-1:0] mul_p;
	logic               div_start;
	logic [DIVD_W-1:0]  div_dividend;
	logic [DSOR_W-1:0]  div_divisor;
	logic [STEP_W-1:0]  div_steps;
	logic               div_done;
	logic [DIVD_W-1:0]  div_quot;
	logic [DSOR_W-1:0]  scaled;
	logic [MP_W-1:0]    sum_adj;
	logic               take;

	assign cmd_mag   = cmd_q[CMD_W-1] ? (CMD_W'(0) - cmd_q) : cmd_q;
	assign delta     = cnt_q - last_cnt_q;
	assign alpha_c   = cfg.filter_alpha[ALPHA_W-1] ? ALPHA_ONE : cfg.filter_alpha;
	assign alpha_inv = ALPHA_ONE - alpha_c;
	assign scaled    = DSOR_W'(prod_q[MP_W-1:LVL_SHIFT]);
	assign take      = (state_q == ST_DONE) && res_ready;

	// shared multiplier, operands picked by the sequencer
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_LMUL: begin
				mul_a = $signed({{(MA_W-CMD_W){1'b0}}, cmd_mag});
				mul_b = $signed({{(MB_W-WRAP_W){1'b0}}, cfg.pwm_wrap});
			end
			ST_LRCP: begin
				mul_a = $signed({5'b0, prod_q[31:4]});
				mul_b = $signed(LVL_RCP);
			end
			ST_SMUL: begin
				mul_a = $signed({1'b0, dmag_q});
				mul_b = $signed(SPEED_SCALE);
			end
			ST_EMA1: begin
				mul_a = $signed({raw_q[SPD_W-1], raw_q});
				mul_b = $signed({{(MB_W-ALPHA_W){1'b0}}, alpha_c});
			end
			ST_EMA2: begin
				mul_a = $signed({last_spd_q[SPD_W-1], last_spd_q});
				mul_b = $signed({{(MB_W-ALPHA_W){1'b0}}, alpha_inv});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign div_start    = (state_q == ST_SGO);
	assign div_dividend = prod_q[DIVD_W-1:0];
	assign div_divisor  = el_q;
	assign div_steps    = SPD_STEPS;

	hbd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (start) state_d = ST_CHECK;
			ST_CHECK: state_d = (cmd_q == '0) ? ST_DONE : ST_LMUL;
			ST_LMUL:  state_d = ST_LRCP;
			ST_LRCP:  state_d = ST_LVL;
			ST_LVL:   state_d = hold_q ? ST_DONE : ST_SMUL;
			ST_SMUL:  state_d = ST_SGO;
			ST_SGO:   state_d = ST_SWAIT;
			ST_SWAIT: if (div_done) state_d = ST_EMA1;
			ST_EMA1:  state_d = ST_EMA2;
			ST_EMA2:  state_d = ST_EMA3;
			ST_EMA3:  state_d = ST_DONE;
			ST_DONE:  if (res_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// (s + 65535) >> 16 rounds a negative sum toward zero
	assign sum_adj = sum_q[MP_W-1] ? (sum_q + MP_W'(65535)) : sum_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_q <= item.speed_cmd;
					cnt_q <= item.encoder_count;
					el_q  <= item.elapsed_us;
				end
			end
			ST_CHECK: begin
				brk_q   <= (cmd_q == '0);
				dir_q   <= !cmd_q[CMD_W-1];
				chg_q   <= (!cmd_q[CMD_W-1] != last_dir_q) || brake_q;
				hold_q  <= (el_q == '0) || (cnt_q[CNT_W-1] != last_cnt_q[CNT_W-1]);
				neg_q   <= delta[CNT_W-1];
				dmag_q  <= delta[CNT_W-1] ? (CNT_W'(0) - delta) : delta;
				speed_q <= last_spd_q;
			end
			ST_LMUL, ST_LRCP, ST_SMUL, ST_EMA1: begin
				prod_q <= mul_p;
			end
			ST_LVL: begin
				level_q <= (scaled >= {{(DSOR_W-WRAP_W){1'b0}}, cfg.pwm_wrap}) ?
					'0 : (cfg.pwm_wrap - scaled[WRAP_W-1:0]);
			end
			ST_SWAIT: begin
				if (div_done) begin
					if (neg_q) begin
						raw_q <= (div_quot > DIVD_W'(64'h8000_0000)) ? 32'h8000_0000 :
							(SPD_W'(0) - div_quot[SPD_W-1:0]);
					end else begin
						raw_q <= (div_quot > DIVD_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF :
							div_quot[SPD_W-1:0];
					end
				end
			end
			ST_EMA2: begin
				sum_q <= prod_q + mul_p;
			end
			ST_EMA3: begin
				speed_q <= sum_adj[SPD_W+15:16];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_dir_q <= 1'b0;
			brake_q    <= 1'b1;
			last_cnt_q <= '0;
			last_spd_q <= '0;
		end else if (take) begin
			brake_q <= brk_q;
			if (!brk_q) begin
				last_dir_q <= dir_q;
				last_cnt_q <= cnt_q;
				last_spd_q <= speed_q;
			end
		end
	end

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);

	always_comb begin
		res.in1_pwm        = !brk_q && !dir_q;
		res.in2_pwm        = !brk_q && dir_q;
		res.pwm_level      = brk_q ? '0 : level_q;
		res.is_braked      = brk_q;
		res.pins_changed   = !brk_q && chg_q;
		res.filtered_speed = speed_q;
	end

endmodule
`default_nettype wire

[sv/hbridge_pwm_drive_with_speed_estimate_top.sv]
// Sequence: when a new speed is computed, the level by reciprocal multiply, then a
// 56-step speed division in the serial divider and the filter; when the speed is held,
// the level only; for a brake request, neither.
// A new request is taken only once the core is idle again; a stalled output holds it off.
// Reset (arst_n low, asynchronous): braked, reverse, count and speed zero,
// pwm_wrap 999, filter_alpha 32768, no result pending.
`default_nettype none
module hbridge_pwm_drive_with_speed_estimate_top import hbd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	// speed_cmd[15:0], encoder_count[47:16], elapsed_us[79:48]
	input  wire logic [IN_W-1:0]    s_tdata,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	// in1_pwm[0], in2_pwm[1], pwm_level[17:2], is_braked[18], pins_changed[19],
	// filtered_speed[51:20], zero fill[55:52]
	output logic [OUT_W-1:0]        m_tdata,
	input  wire logic               cfg_we,
	input  wire logic [CFGA_W-1:0]  cfg_index,
	input  wire logic [ALPHA_W-1:0] cfg_data
);

	logic [WRAP_W-1:0]  wrap_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic               m_valid_q;
	logic [OUT_W-1:0]   m_data_q;
	hbd_item_t          item;
	hbd_cfg_t           cfg;
	hbd_res_t           res;
	logic               core_idle;
	logic               res_valid;
	logic               res_ready;
	logic               start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q  <= WRAP_RST;
			alpha_q <= ALPHA_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PWM_WRAP:     wrap_q  <= cfg_data[WRAP_W-1:0];
				REG_FILTER_ALPHA: alpha_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign item.speed_cmd     = s_tdata[15:0];
	assign item.encoder_count = s_tdata[47:16];
	assign item.elapsed_us    = s_tdata[79:48];
	assign cfg.pwm_wrap       = wrap_q;
	assign cfg.filter_alpha   = alpha_q;

	assign s_tready  = core_idle;
	assign start     = s_tvalid && core_idle;
	assign res_ready = !m_valid_q || m_tready;

	hbd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.cfg       (cfg),
		.res_ready (res_ready),
		.idle      (core_idle),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_data_q <= {4'b0, res.filtered_speed, res.pins_changed, res.is_braked,
				res.pwm_level, res.in2_pwm, res.in1_pwm};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// the core is not ready again in the cycle after it takes a request
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("core ready right after taking a request");

	// a braked result drives no PWM and a zero level
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[18] |-> (m_tdata[17:0] == 18'd0) && !m_tdata[19])
		else $error("braked result carries PWM assignment");

	// never both inputs switching at once
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("both bridge inputs carry PWM");

endmodule
`default_nettype wire

[tb/hbd_drive_checker.sv]
// Checker for the H-bridge drive block: models the drive state and compares every result.
`timescale 1ns / 100ps
module hbd_drive_checker import hbd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	input  wire logic               s_tready,
	input  wire logic [IN_W-1:0]    s_tdata,
	input  wire logic               m_tvalid,
	input  wire logic               m_tready,
	input  wire logic [OUT_W-1:0]   m_tdata,
	input  wire logic               cfg_we,
	input  wire logic [CFGA_W-1:0]  cfg_index,
	input  wire logic [ALPHA_W-1:0] cfg_data,
	output int                      mismatches,
	output int                      outstanding,
	output int                      results_checked
);

	localparam int MAX_REPORTS = 50;

	// drive state and register copies
	logic [WRAP_W-1:0]  wrap_cfg;
	logic [ALPHA_W-1:0] alpha_cfg;
	logic               dir_fwd;
	logic               braked;
	logic [CNT_W-1:0]   count_prev;
	logic [SPD_W-1:0]   speed_prev;

	hbd_res_t drive_results_q[$];
	int n_err;
	int n_res;

	assign mismatches      = n_err;
	assign results_checked = n_res;

	// count delta scaled to millirad/s, truncated and clamped to int32
	function automatic logic [SPD_W-1:0] shaft_rate(logic [CNT_W-1:0] cnt,
		logic [EL_W-1:0] el);
		logic [CNT_W-1:0] d;
		logic             neg;
		logic [63:0]      mag;
		logic [63:0]      q;
		d   = cnt - count_prev;
		neg = d[31];
		mag = {32'd0, neg ? (32'd0 - d) : d};
		q   = (mag * 64'(SPEED_SCALE)) / {32'd0, el};
		if (neg) begin
			if (q > 64'h8000_0000)
				q = 64'h8000_0000;
			return 32'd0 - q[31:0];
		end
		if (q > 64'h7FFF_FFFF)
			q = 64'h7FFF_FFFF;
		return q[31:0];
	endfunction

	function automatic logic [SPD_W-1:0] smooth_speed(logic [SPD_W-1:0] fresh);
		longint a;
		longint acc;
		a   = (alpha_cfg > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_cfg);
		acc = a * longint'($signed(fresh))
			+ (longint'(ALPHA_ONE) - a) * longint'($signed(speed_prev));
		// signed division truncates toward zero
		return 32'(acc / longint'(ALPHA_ONE));
	endfunction

	function automatic hbd_res_t predict_drive(logic [CMD_W-1:0] cmd, logic [CNT_W-1:0] cnt,
		logic [EL_W-1:0] el);
		hbd_res_t         r;
		logic             fwd;
		logic [16:0]      mag;
		logic [31:0]      scaled;
		logic [SPD_W-1:0] spd;
		r = '0;
		if (cmd == '0) begin
			braked           = 1'b1;
			r.is_braked      = 1'b1;
			r.filtered_speed = speed_prev;
			return r;
		end
		fwd            = ~cmd[15];
		mag            = fwd ? {1'b0, cmd} : (17'h10000 - {1'b0, cmd});
		r.pins_changed = (fwd != dir_fwd) || braked;
		dir_fwd        = fwd;
		braked         = 1'b0;
		scaled         = (32'(mag) * 32'(wrap_cfg)) / CMD_FULL;
		r.pwm_level    = (scaled >= 32'(wrap_cfg)) ? '0 : 16'(32'(wrap_cfg) - scaled);
		// hold the speed on zero elapsed time or a count sign flip
		if (el == '0 || (cnt[31] != count_prev[31]))
			spd = speed_prev;
		else
			spd = smooth_speed(shaft_rate(cnt, el));
		count_prev       = cnt;
		speed_prev       = spd;
		r.in1_pwm        = ~fwd;
		r.in2_pwm        = fwd;
		r.filtered_speed = spd;
		return r;
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			n_err++;
			if (n_err <= MAX_REPORTS)
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
			else if (n_err == MAX_REPORTS + 1)
				$display("%0t: further mismatches not shown", $time);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hbd_res_t want;
		hbd_res_t got;
		if (!arst_n) begin
			wrap_cfg   = WRAP_RST;
			alpha_cfg  = ALPHA_RST;
			dir_fwd    = 1'b0;
			braked     = 1'b1;
			count_prev = '0;
			speed_prev = '0;
			drive_results_q.delete();
			n_err      = 0;
			n_res      = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PWM_WRAP:     wrap_cfg = cfg_data[WRAP_W-1:0];
					REG_FILTER_ALPHA: alpha_cfg = cfg_data;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.in1_pwm        = m_tdata[0];
				got.in2_pwm        = m_tdata[1];
				got.pwm_level      = m_tdata[17:2];
				got.is_braked      = m_tdata[18];
				got.pins_changed   = m_tdata[19];
				got.filtered_speed = m_tdata[51:20];
				if (drive_results_q.size() == 0) begin
					n_err++;
					$display("%0t: result with nothing pending: expected none, got %h",
						$time, m_tdata);
				end else begin
					want = drive_results_q.pop_front();
					n_res++;
					check_field("in1_pwm", want.in1_pwm, got.in1_pwm);
					check_field("in2_pwm", want.in2_pwm, got.in2_pwm);
					check_field("pwm_level", want.pwm_level, got.pwm_level);
					check_field("is_braked", want.is_braked, got.is_braked);
					check_field("pins_changed", want.pins_changed, got.pins_changed);
					check_field("filtered_speed", longint'(want.filtered_speed),
						longint'(got.filtered_speed));
				end
			end
			if (s_tvalid && s_tready)
				drive_results_q.push_back(predict_drive(s_tdata[15:0], s_tdata[47:16],
					s_tdata[79:48]));
			outstanding <= drive_results_q.size();
		end
	end

endmodule

[tb/hbridge_pwm_drive_with_speed_estimate_top_tb.sv]
// Testbench top for the H-bridge drive block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module hbridge_pwm_drive_with_speed_estimate_top_tb import hbd_pkg::*;;

	localparam int RESET_CYCLES   = 11;
	localparam int HOLD_CYCLES    = 600;
	localparam int TAIL_CYCLES    = 120;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES         = 6;
	localparam int PER_PROFILE    = 30;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               s_tvalid  = 1'b0;
	logic [IN_W-1:0]    s_tdata   = '0;
	logic               m_tready  = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [CFGA_W-1:0]  cfg_index = '0;
	logic [ALPHA_W-1:0] cfg_data  = '0;
	wire                s_tready;
	wire                m_tvalid;
	wire [OUT_W-1:0]    m_tdata;

	int mismatches;
	int outstanding;
	int results_checked;

	int idle_pct    = 0;
	int stall_pct   = 0;
	int hold_reqs   = 0;
	int n_sent      = 0;
	int n_directed  = 0;
	int track_count = 0;

	hbridge_pwm_drive_with_speed_estimate_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	hbd_drive_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// result side: random stalls, plus a long hold-off when one is requested
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: timeout, nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [CNT_W-1:0] cnt,
		input logic [EL_W-1:0] el);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {el, cnt, cmd};
		do @(posedge clk); while (!s_tready);
		n_sent++;
	endtask

	task automatic send_random_req();
		logic [CMD_W-1:0] cmd;
		logic [CNT_W-1:0] cnt;
		logic [EL_W-1:0]  el;
		if ($urandom_range(0, 99) < 65) begin
			// plausible motion: steady count steps, control-loop intervals
			if ($urandom_range(0, 29) == 0)
				track_count = int'($urandom_range(0, 4000)) - 2000;
			track_count += int'($urandom_range(0, 8000)) - 4000;
			cmd = ($urandom_range(0, 11) == 0) ? '0 : 16'(int'($urandom_range(0, 20000)) - 10000);
			cnt = track_count;
			el  = ($urandom_range(0, 19) == 0) ? '0 : 32'($urandom_range(50, 20000));
		end else begin
			cmd = ($urandom_range(0, 15) == 0) ? '0 : 16'($urandom);
			cnt = $urandom;
			case ($urandom_range(0, 3))
				0:       el = $urandom_range(0, 3);
				1:       el = $urandom >> $urandom_range(0, 31);
				default: el = $urandom;
			endcase
			track_count = cnt;
		end
		send_req(cmd, cnt, el);
	endtask

	// hold the input off until every expected result is in
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic load_setting(input logic [ALPHA_W-1:0] wrap_word,
		input logic [ALPHA_W-1:0] alpha);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PWM_WRAP;
		cfg_data  <= wrap_word;
		@(posedge clk);
		cfg_index <= REG_FILTER_ALPHA;
		cfg_data  <= alpha;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int p;
		int m;
		int k;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: brake, both directions, extremes, held speed, saturation
		send_req(16'd0, 32'd0, 32'd0);
		send_req(16'd10000, 32'd100, 32'd1000);
		send_req(16'd10000, 32'd300, 32'd1000);
		send_req(-16'sd10000, 32'd200, 32'd1000);
		send_req(16'h7FFF, 32'd1200, 32'd500);
		send_req(16'h8000, 32'd1100, 32'd500);
		send_req(16'd1, 32'd1150, 32'd0);
		send_req(16'hFFFF, 32'd1150, 32'hFFFF_FFFF);
		send_req(16'd5000, -32'sd50, 32'd1000);
		send_req(16'd5000, -32'sd300, 32'd1000);
		send_req(16'd0, 32'd12345, 32'd77);
		send_req(16'd5000, -32'sd200, 32'd1000);
		send_req(-16'sd5000, 32'h7FFF_FFFF, 32'd1);
		send_req(-16'sd5000, 32'd0, 32'd1);
		send_req(-16'sd5000, 32'h7FFF_FFFF, 32'd1);
		send_req(16'd7000, 32'h8000_0000, 32'd5);
		send_req(16'd7000, 32'hFFFF_FFFF, 32'd1);
		send_req(16'd7000, 32'h8000_0000, 32'd1);
		send_req(16'd9999, 32'h8000_0010, 32'd3);
		send_req(-16'sd9999, 32'h8000_0000, 32'd7);
		send_req(16'd0, 32'd0, 32'd0);
		send_req(16'h8001, 32'd0, 32'd2);
		send_req(16'h8001, 32'd40, 32'd1);
		n_directed = n_sent;
		drain();

		for (p = 0; p < PHASES; p++) begin
			case (p)
				1: load_setting(17'd1, ALPHA_ONE);
				2: load_setting(17'd65535, 17'd0);
				3: load_setting(17'd10000, 17'h1FFFF);
				4: load_setting({1'($urandom_range(0, 1)), 16'($urandom_range(1, 65535))},
					17'($urandom_range(0, 131071)));
				5: load_setting(17'h10000 | 17'd999, 17'd1);
				default: ;
			endcase
			for (m = 0; m < 4; m++) begin
				case (m)
					0: begin idle_pct = 0;  stall_pct = 0;  end
					1: begin idle_pct = 72; stall_pct = 0;  end
					2: begin idle_pct = 0;  stall_pct = 72; end
					3: begin idle_pct = 29; stall_pct = 29; end
				endcase
				// long receiver hold-off while requests keep coming
				if (p == 1 && m == 0)
					hold_reqs <= hold_reqs + 1;
				for (k = 0; k < PER_PROFILE; k++)
					send_random_req();
				if (p == 2 && m == 1)
					drain();
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d drive requests (%0d directed) over %0d register settings and",
			n_sent, n_directed, PHASES);
		$display("four idle profiles with a long output hold-off; %0d results checked.",
			results_checked);
		if (mismatches == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[hbridge_pwm_drive_with_speed_estimate_top.f]
sv/hbd_pkg.sv
sv/hbd_div.sv
sv/hbd_core.sv
sv/hbridge_pwm_drive_with_speed_estimate_top.sv
tb/hbd_drive_checker.sv
tb/hbridge_pwm_drive_with_speed_estimate_top_tb.sv
